### rtl/adlm_pkg.sv
`timescale 1ns / 1ps
// constants, register indexes and arithmetic helpers for audio_delay_line_mix
// no dependencies
package adlm_pkg;

	localparam int MAX_LINE    = 131072;
	localparam int SAMPLE_BITS = 16;

	localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int ADDR_W  = $clog2(MAX_LINE);
	localparam int LEN_W   = ADDR_W + 1;
	localparam int DELAY_W = 17;
	localparam int GAIN_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int FRAC    = 15;

	localparam logic [GAIN_W-1:0]  UNITY       = GAIN_W'(32768);
	localparam logic [DELAY_W-1:0] MIN_DELAY   = DELAY_W'(256);
	localparam logic [DELAY_W-1:0] RESET_DELAY = DELAY_W'(48000);
	localparam logic [GAIN_W-1:0]  RESET_WET   = GAIN_W'(16384);
	localparam logic [GAIN_W-1:0]  RESET_FB    = GAIN_W'(0);

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (FRAC - 1));
	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_TIME    = 2'd0,
		REG_WET_GAIN      = 2'd1,
		REG_FEEDBACK_GAIN = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_reg_t;

	// line length: twice the delay, delay floored at the minimum, capped at the store depth
	function automatic logic [LEN_W-1:0] line_length(input logic [DELAY_W-1:0] d);
		logic [DELAY_W-1:0] dd;
		logic [DELAY_W+1:0] two_d;
		logic [LEN_W-1:0] len;
		dd    = (d < MIN_DELAY) ? MIN_DELAY : d;
		two_d = {1'b0, dd, 1'b0};
		if ((DELAY_W + 2 > LEN_W) && (two_d > (DELAY_W + 2)'(MAX_LINE)))
			len = LEN_W'(MAX_LINE);
		else
			len = LEN_W'(two_d);
		return len;
	endfunction

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return (g > UNITY) ? UNITY : g;
	endfunction

	// round half up from q.30 to q.15, then saturate to the sample range
	function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = (v + ROUND_HALF) >>> FRAC;
		if (r > SAT_HI)
			r = SAT_HI;
		else if (r < SAT_LO)
			r = SAT_LO;
		return r[SAMPLE_BITS-1:0];
	endfunction

endpackage

### rtl/audio_delay_line_mix.sv
`timescale 1ns / 1ps
// audio_delay_line_mix: circular delay line with wet/dry mix, one sample per transfer
// depends on adlm_pkg
//
// Usage
//   s_axis carries one signed q1.15 sample in tdata and the host block end flag in tlast.
//   m_axis returns the mixed, saturated sample in tdata with tlast copied from the input.
//   cfg writes registers by index: 0 delay_time, 1 wet_gain, 2 feedback_gain; other
//   indexes are ignored. cfg_ready is always high; write only while no samples are in flight.
// Timing
//   three register stages: stage 1, stage 2 and the output register, which drives m_axis.
//   one sample per cycle sustained while m_axis does not stall; one memory read port
//   (at acceptance) and one write port (as a sample leaves stage 1) set that rate.
// Reset and delay changes
//   reset or a delay_time write sets the head to zero and marks the line as empty; until the
//   head first wraps, entries read as zero, so no clearing pass is needed and the block
//   accepts samples straight after reset.
// Stalls
//   when m_axis stalls, the stages fill up; s_axis_tready drops only once all three stages
//   hold a sample, and nothing is lost or repeated.
module audio_delay_line_mix (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [adlm_pkg::DATA_W-1:0]     s_axis_tdata,  // [15:0] in_sample
	input  logic                            s_axis_tlast,  // block_end
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [adlm_pkg::DATA_W-1:0]     m_axis_tdata,  // [15:0] out_sample
	output logic                            m_axis_tlast,  // block_end_out
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [adlm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adlm_pkg::DELAY_W-1:0]    cfg_data
);
	import adlm_pkg::*;

	// configuration
	logic [GAIN_W-1:0] wet_q, fb_q;
	logic [LEN_W-1:0]  len_q;
	logic              cfg_wr;

	// head and fill state
	logic [ADDR_W-1:0] head_q;
	logic              wrap_q;
	logic [LEN_W-1:0]  head_inc;
	logic              head_end;

	// pipeline
	logic                          v1_q, v2_q, vo_q;
	logic                          acc, ld_s2, ld_o;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          last_s1, last_s2, last_q;
	logic [ADDR_W-1:0]             addr_s1;
	logic                          seen_s1;
	logic [SAMPLE_BITS-1:0]        rd_s1;
	logic signed [PROD_W-1:0]      pd_s2, pw_s2;
	logic [SAMPLE_BITS-1:0]        out_q;

	logic [GAIN_W-1:0]             wet_c, dry_c, fb_c;
	logic signed [SAMPLE_BITS-1:0] ent;
	logic signed [PROD_W-1:0]      pd_c, pw_c, pf_c;
	logic [SAMPLE_BITS-1:0]        wr_data;
	logic signed [SUM_W-1:0]       mix_sum;

	logic [SAMPLE_BITS-1:0] mem [MAX_LINE];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign ld_o          = v2_q && (!vo_q || m_axis_tready);
	assign ld_s2         = v1_q && (!v2_q || ld_o);
	assign s_axis_tready = !v1_q || ld_s2;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign head_inc = LEN_W'(head_q) + LEN_W'(1);
	assign head_end = (head_inc >= len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q  <= RESET_WET;
			fb_q   <= RESET_FB;
			len_q  <= line_length(RESET_DELAY);
			head_q <= '0;
			wrap_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_reg_t'(cfg_index))
					REG_DELAY_TIME: begin
						len_q  <= line_length(cfg_data);
						head_q <= '0;
						wrap_q <= 1'b0;
					end
					REG_WET_GAIN:      wet_q <= cfg_data[GAIN_W-1:0];
					REG_FEEDBACK_GAIN: fb_q  <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end else if (acc) begin
				if (head_end) begin
					head_q <= '0;
					wrap_q <= 1'b1;
				end else begin
					head_q <= head_inc[ADDR_W-1:0];
				end
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (acc)
				v1_q <= 1'b1;
			else if (ld_s2)
				v1_q <= 1'b0;
			if (ld_s2)
				v2_q <= 1'b1;
			else if (ld_o)
				v2_q <= 1'b0;
			if (ld_o)
				vo_q <= 1'b1;
			else if (m_axis_tready)
				vo_q <= 1'b0;
		end
	end

	// read at the head on accept, write the scaled input as the sample leaves stage 1
	always_ff @(posedge clk) begin
		if (ld_s2)
			mem[addr_s1] <= wr_data;
		if (acc)
			rd_s1 <= mem[head_q];
	end

	always_comb begin
		wet_c   = clamp_gain(wet_q);
		dry_c   = UNITY - wet_c;
		fb_c    = clamp_gain(fb_q);
		// entries past the head read as zero until the line has wrapped once
		ent     = seen_s1 ? signed'(rd_s1) : '0;
		pd_c    = PROD_W'(x_s1) * PROD_W'($signed({1'b0, dry_c}));
		pw_c    = PROD_W'(ent) * PROD_W'($signed({1'b0, wet_c}));
		pf_c    = PROD_W'(x_s1) * PROD_W'($signed({1'b0, fb_c}));
		wr_data = round_sat(SUM_W'(pf_c));
		mix_sum = SUM_W'(pd_s2) + SUM_W'(pw_s2);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1    <= signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
			last_s1 <= s_axis_tlast;
			addr_s1 <= head_q;
			seen_s1 <= wrap_q;
		end
		if (ld_s2) begin
			pd_s2   <= pd_c;
			pw_s2   <= pw_c;
			last_s2 <= last_s1;
		end
		if (ld_o) begin
			out_q  <= round_sat(mix_sum);
			last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = DATA_W'(out_q);
	assign m_axis_tlast  = last_q;

	a_head_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(head_q) < len_q)
		else $error("head beyond line length");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q >= LEN_W'(512)) && (len_q <= LEN_W'(MAX_LINE)))
		else $error("line length out of range");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_s2 && acc) |-> (addr_s1 != head_q))
		else $error("write and read at the same entry");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v1_q && v2_q && vo_q))
		else $error("input stalled with a free stage");

	a_delay_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && (cfg_index == REG_DELAY_TIME)) |=> (head_q == '0 && !wrap_q))
		else $error("delay write did not restart the line");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for audio_delay_line_mix: directed and random sample streams
// depends on adlm_pkg and the audio_delay_line_mix rtl
module tb_top;
	import adlm_pkg::*;

	localparam int ITEMS_PER_PHASE = 136;
	localparam int PHASES          = 12;
	localparam int LAT_PAD         = 8;
	localparam int IDLE_LIMIT      = 2000;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} mix_out_t;

	// delay line and wet/dry mix, one expected output per accepted sample
	class delay_mix_scoreboard;
		logic signed [SAMPLE_BITS-1:0] line_mem [MAX_LINE];
		int unsigned                   head;
		int unsigned                   line_len;
		logic [GAIN_W-1:0]             wet_reg;
		logic [GAIN_W-1:0]             fb_reg;
		mix_out_t                      pending_mix [$];
		int                            errors;

		function new();
			errors  = 0;
			wet_reg = RESET_WET;
			fb_reg  = RESET_FB;
			set_delay(RESET_DELAY);
		endfunction

		function void set_delay(input logic [DELAY_W-1:0] d);
			int unsigned eff;
			eff       = (d < 256) ? 256 : int'(d);
			line_len  = (2 * eff > MAX_LINE) ? MAX_LINE : 2 * eff;
			head      = 0;
			foreach (line_mem[i])
				line_mem[i] = '0;
		endfunction

		function void apply_reg(input cfg_reg_t idx, input logic [DELAY_W-1:0] v);
			case (idx)
				REG_DELAY_TIME:    set_delay(v);
				REG_WET_GAIN:      wet_reg = v[GAIN_W-1:0];
				REG_FEEDBACK_GAIN: fb_reg = v[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// q.30 to q.15, round half up, then saturate
		function logic signed [SAMPLE_BITS-1:0] round_q30(input longint acc);
			longint r;
			longint hi;
			hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			r  = (acc + 64'sd16384) >>> 15;
			if (r > hi)
				r = hi;
			else if (r < -hi - 1)
				r = -hi - 1;
			return r[SAMPLE_BITS-1:0];
		endfunction

		function void accept_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
			longint   x;
			longint   entry;
			longint   wet;
			longint   dry;
			longint   fb;
			mix_out_t res;
			x     = smp;
			entry = line_mem[head];
			wet   = (wet_reg > UNITY) ? longint'(UNITY) : longint'(wet_reg);
			dry   = longint'(UNITY) - wet;
			fb    = (fb_reg > UNITY) ? longint'(UNITY) : longint'(fb_reg);
			res.sample     = round_q30(x * dry + entry * wet);
			res.last       = last;
			line_mem[head] = round_q30(x * fb);
			head           = (head + 1 >= line_len) ? 0 : head + 1;
			pending_mix.push_back(res);
		endfunction

		function void check_output(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
			mix_out_t want;
			if (pending_mix.size() == 0) begin
				note_error();
				if (errors <= 10)
					$display("unexpected output transfer: out_sample %0d block_end_out %0b",
						smp, last);
				return;
			end
			want = pending_mix.pop_front();
			if (want.sample !== smp || want.last !== last) begin
				note_error();
				if (errors <= 10)
					$display("mismatch: out_sample exp %0d got %0d, block_end_out exp %0b got %0b",
						want.sample, smp, want.last, last);
			end
		endfunction

		function void note_error();
			errors++;
		endfunction

		function int pending_count();
			return pending_mix.size();
		endfunction

		function void finish_check();
			if (pending_mix.size() != 0) begin
				note_error();
				$display("%0d expected outputs never arrived", pending_mix.size());
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [DATA_W-1:0]    m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DELAY_W-1:0]   cfg_data;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int          quiet_cycles;

	delay_mix_scoreboard sb = new();

	audio_delay_line_mix u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side: random back-pressure, set at the falling edge
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata[SAMPLE_BITS-1:0], m_axis_tlast);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp, input logic last);
		while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'(smp);
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.accept_sample(smp, last);
		@(negedge clk);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [DELAY_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.apply_reg(idx, v);
		@(negedge clk);
	endtask

	// always lets at least the pipeline latency pass
	task automatic drain_results();
		while (sb.pending_count() != 0)
			@(negedge clk);
		repeat (LAT_PAD) @(negedge clk);
	endtask

	function automatic logic [DELAY_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return DELAY_W'(UNITY);
			2:       return DELAY_W'(16'hFFFF);
			3:       return DELAY_W'($urandom_range(0, 32768));
			default: return DELAY_W'($urandom_range(0, 17'h1FFFF));
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return SAMPLE_BITS'($urandom_range(0, 3) - 2);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tlast   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_DELAY_TIME;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: output is half the input
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h0001, 1'b0);
		push_sample(16'hFFFF, 1'b1);
		s_axis_tvalid <= 1'b0;

		// short delay, both gains above unity
		drain_results();
		write_reg(REG_DELAY_TIME, '0);
		write_reg(REG_WET_GAIN, 17'h0FFFF);
		write_reg(REG_FEEDBACK_GAIN, 17'h0FFFF);
		// unknown register must change nothing
		write_reg(REG_UNUSED, 17'h1FFFF);
		cfg_valid <= 1'b0;
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h0001, 1'b0);
		s_axis_tvalid <= 1'b0;

		// dry only, gain change keeps the line
		drain_results();
		write_reg(REG_WET_GAIN, '0);
		write_reg(REG_FEEDBACK_GAIN, DELAY_W'(UNITY));
		cfg_valid <= 1'b0;
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		s_axis_tvalid <= 1'b0;

		// long delay beyond the store, then a line exactly the store depth, then one just past it
		drain_results();
		write_reg(REG_DELAY_TIME, 17'h1FFFF);
		write_reg(REG_WET_GAIN, DELAY_W'(UNITY));
		cfg_valid <= 1'b0;
		push_sample(16'h1234, 1'b0);
		push_sample(16'hEDCC, 1'b1);
		s_axis_tvalid <= 1'b0;
		drain_results();
		write_reg(REG_DELAY_TIME, 17'd65536);
		cfg_valid <= 1'b0;
		push_sample(16'h7FFF, 1'b0);
		s_axis_tvalid <= 1'b0;
		drain_results();
		write_reg(REG_DELAY_TIME, 17'd65537);
		cfg_valid <= 1'b0;
		push_sample(16'h8000, 1'b1);
		s_axis_tvalid <= 1'b0;

		// half gains: rounding of plus and minus one half
		drain_results();
		write_reg(REG_DELAY_TIME, 17'd256);
		write_reg(REG_WET_GAIN, 17'd16384);
		write_reg(REG_FEEDBACK_GAIN, 17'd16384);
		cfg_valid <= 1'b0;
		push_sample(16'h0001, 1'b0);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h0003, 1'b1);
		push_sample(16'hFFFD, 1'b0);
		s_axis_tvalid <= 1'b0;

		// random phases; the delay is rewritten every fourth phase so a short line wraps between
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			if (ph % 4 == 0) begin
				case (ph / 4)
					0:       write_reg(REG_DELAY_TIME, '0);
					1:       write_reg(REG_DELAY_TIME, 17'd257);
					default: write_reg(REG_DELAY_TIME, DELAY_W'($urandom_range(0, 17'h1FFFF)));
				endcase
			end
			write_reg(REG_WET_GAIN, pick_gain());
			write_reg(REG_FEEDBACK_GAIN, pick_gain());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, DELAY_W'($urandom_range(0, 17'h1FFFF)));
			cfg_valid <= 1'b0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				push_sample(pick_sample(), $urandom_range(0, 7) == 0);
				// hold the sender off until the pipeline is empty
				if (i == ITEMS_PER_PHASE / 2) begin
					s_axis_tvalid <= 1'b0;
					drain_results();
				end
			end
			s_axis_tvalid <= 1'b0;
		end

		drain_results();
		sb.finish_check();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### audio_delay_line_mix.f
rtl/adlm_pkg.sv
rtl/audio_delay_line_mix.sv
dv/tb_top.sv
